FILE: src/rleg_pkg.sv
package rleg_pkg;

  typedef enum logic [1:0] {
    PH_CTRL  = 2'd0,
    PH_VALUE = 2'd1,
    PH_LIT   = 2'd2
  } phase_e;

  localparam int unsigned PIX_PER_WORD = 8;
  localparam logic [3:0]  NIB_MASK     = 4'hF;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  run_left;
    logic [31:0] pend;
    logic [2:0]  pcnt;
    logic        complete;
  } dec_state_t;

  localparam dec_state_t DEC_RESET = '{
    phase:    PH_CTRL,
    run_left: 3'd0,
    pend:     32'd0,
    pcnt:     3'd0,
    complete: 1'b1
  };

  localparam dec_state_t DEC_START = '{
    phase:    PH_CTRL,
    run_left: 3'd0,
    pend:     32'd0,
    pcnt:     3'd0,
    complete: 1'b0
  };

endpackage

FILE: src/nibble_rle_glyph_decoder.sv
// channel | dir | handshake                   | payload
// input   | in  | in_valid_i / in_stall_o     | data_byte_i, glyph_start_i
// output  | out | out_valid_o / out_stall_i   | pixel_word_o, word_index_o, last_word_o
//
// one byte per cycle unless a stalled output holds the pipe: input register, two chained nibble steps, result register
// a byte's word goes from the input register through the result register to the outputs, at most one word per byte
// rst_ni clears the decoder to waiting for a glyph start
// a stalled output holds the pipe; input stall follows output stall while both registers are full
module nibble_rle_glyph_decoder #(
  parameter int unsigned GLYPH_PIXELS = 576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        glyph_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_word_o,
  output logic [6:0]  word_index_o,
  output logic        last_word_o
);

  localparam int unsigned GLYPH_WORDS = GLYPH_PIXELS / 8;
  localparam int unsigned WORDS_W     = $clog2(GLYPH_WORDS + 1);
  localparam logic [6:0]  LAST_IDX    = 7'((GLYPH_WORDS - 1) % 128);

  logic                 in_vld_q;
  logic [7:0]           byte_q;
  logic                 start_q;
  logic                 adv;
  logic                 step;

  rleg_pkg::dec_state_t st_q, st_d, st0, st1;
  logic [WORDS_W-1:0]   words_q, words_d, words0, words1;

  logic                 vld_a, vld_b, last_a, last_b;
  logic [31:0]          word_a, word_b;
  logic [6:0]           idx_a, idx_b;

  logic                 out_vld_q;
  logic [31:0]          out_word_q;
  logic [6:0]           out_idx_q;
  logic                 out_last_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= data_byte_i;
      start_q <= glyph_start_i;
    end
  end

  // glyph start wipes the decoder before the byte is decoded
  assign st0    = start_q ? rleg_pkg::DEC_START : st_q;
  assign words0 = start_q ? '0 : words_q;

  rleg_nibble #(
    .GLYPH_WORDS (GLYPH_WORDS),
    .WORDS_W     (WORDS_W)
  ) u_nib_hi (
    .st_i       (st0),
    .words_i    (words0),
    .nib_i      (byte_q[7:4]),
    .st_o       (st1),
    .words_o    (words1),
    .word_vld_o (vld_a),
    .word_o     (word_a),
    .index_o    (idx_a),
    .last_o     (last_a)
  );

  rleg_nibble #(
    .GLYPH_WORDS (GLYPH_WORDS),
    .WORDS_W     (WORDS_W)
  ) u_nib_lo (
    .st_i       (st1),
    .words_i    (words1),
    .nib_i      (byte_q[3:0]),
    .st_o       (st_d),
    .words_o    (words_d),
    .word_vld_o (vld_b),
    .word_o     (word_b),
    .index_o    (idx_b),
    .last_o     (last_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= rleg_pkg::DEC_RESET;
      words_q <= '0;
    end else if (step) begin
      st_q    <= st_d;
      words_q <= words_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q && (vld_a || vld_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && (vld_a || vld_b)) begin
      if (vld_a) begin
        out_word_q <= word_a;
        out_idx_q  <= idx_a;
        out_last_q <= last_a;
      end else begin
        out_word_q <= word_b;
        out_idx_q  <= idx_b;
        out_last_q <= last_b;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign pixel_word_o = out_word_q;
  assign word_index_o = out_idx_q;
  assign last_word_o  = out_last_q;

  a_last_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_word_o |-> word_index_o == LAST_IDX)
    else $error("last word with wrong index");

  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_word_o |-> st_q.complete)
    else $error("decoder still active after last word");

  a_words_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.complete |-> words_q < WORDS_W'(GLYPH_WORDS))
    else $error("word count past glyph end while decoding");

endmodule

FILE: src/rleg_nibble.sv
module rleg_nibble #(
  parameter int unsigned GLYPH_WORDS = 72,
  parameter int unsigned WORDS_W     = 7
) (
  input  rleg_pkg::dec_state_t st_i,
  input  logic [WORDS_W-1:0]   words_i,
  input  logic [3:0]           nib_i,
  output rleg_pkg::dec_state_t st_o,
  output logic [WORDS_W-1:0]   words_o,
  output logic                 word_vld_o,
  output logic [31:0]          word_o,
  output logic [6:0]           index_o,
  output logic                 last_o
);

  logic [3:0]           run_n;
  logic [3:0]           total;
  logic [3:0]           over;
  logic [31:0]          merged;
  logic [31:0]          spill;
  logic                 full;
  logic [WORDS_W+6:0]   words_ext;
  logic [WORDS_W:0]     words_inc;
  rleg_pkg::dec_state_t st_ph;

  // phase step: how many copies of this nibble go into the word
  always_comb begin
    st_ph = st_i;
    run_n = 4'd0;
    unique case (st_i.phase)
      rleg_pkg::PH_VALUE: begin
        run_n        = {1'b0, st_i.run_left};
        st_ph.run_left = 3'd0;
        st_ph.phase    = rleg_pkg::PH_CTRL;
      end
      rleg_pkg::PH_LIT: begin
        run_n          = 4'd1;
        st_ph.run_left = st_i.run_left - 3'd1;
        if (st_i.run_left == 3'd1) begin
          st_ph.phase = rleg_pkg::PH_CTRL;
        end
      end
      default: begin
        st_ph.run_left = nib_i[2:0];
        if (nib_i[3]) begin
          st_ph.phase = rleg_pkg::PH_VALUE;
        end else if (nib_i[2:0] != 3'd0) begin
          st_ph.phase = rleg_pkg::PH_LIT;
        end else begin
          st_ph.phase = rleg_pkg::PH_CTRL;
        end
      end
    endcase
  end

  assign total = {1'b0, st_i.pcnt} + run_n;
  assign full  = (total >= 4'(rleg_pkg::PIX_PER_WORD));
  assign over  = total - 4'(rleg_pkg::PIX_PER_WORD);

  // fill slots pcnt..total-1, spill past the word boundary into the next one
  always_comb begin
    merged = st_i.pend;
    spill  = 32'd0;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) >= {1'b0, st_i.pcnt}) && (4'(i) < total)) begin
        merged[4*i +: 4] = nib_i & rleg_pkg::NIB_MASK;
      end
      if (4'(i) < over) begin
        spill[4*i +: 4] = nib_i & rleg_pkg::NIB_MASK;
      end
    end
  end

  assign words_ext = {7'd0, words_i};
  assign words_inc = {1'b0, words_i} + {{WORDS_W{1'b0}}, 1'b1};

  always_comb begin
    st_o       = st_ph;
    words_o    = words_i;
    word_vld_o = 1'b0;
    word_o     = merged;
    index_o    = words_ext[6:0];
    last_o     = (words_inc >= (WORDS_W+1)'(GLYPH_WORDS));
    if (st_i.complete) begin
      st_o = st_i;
    end else if (full) begin
      word_vld_o = 1'b1;
      words_o    = words_inc[WORDS_W-1:0];
      if (last_o) begin
        // rest of the run and of the byte is dropped
        st_o.complete = 1'b1;
        st_o.pend     = 32'd0;
        st_o.pcnt     = 3'd0;
      end else begin
        st_o.pend = spill;
        st_o.pcnt = over[2:0];
      end
    end else begin
      st_o.pend = merged;
      st_o.pcnt = total[2:0];
    end
  end

endmodule
